@@ src/mpd_pkg.sv @@
// ----------------------------------------------------------------------------
// Pixel downscaler package
// Widths, buffer geometry, register indexes and the divider stage record
// shared by the downscaler, its channel interfaces and its top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mpd_pkg;

  // Buffer geometry of the square output image.
  localparam int unsigned BUFFER_WIDTH  = 240;
  localparam int unsigned BUFFER_HEIGHT = 240;

  // Field widths.
  localparam int unsigned BLOCK_IDX_W = 13;
  localparam int unsigned PIX_IDX_W   = 4;
  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned PIX565_W    = 16;

  // Configuration register widths.
  localparam int unsigned DIM_W   = 16;
  localparam int unsigned BLK_W   = 5;
  localparam int unsigned OSIZE_W = 8;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Source coordinate: 13-bit block index times 5-bit block size plus 4 bits.
  localparam int unsigned SRC_W = 18;
  // Dividend: a kept source coordinate is below the 16-bit dimension,
  // times the 8-bit output size.
  localparam int unsigned NUM_W = DIM_W + OSIZE_W;
  // Quotient is below the square side, so it fits the output size width.
  localparam int unsigned QUO_W = OSIZE_W;
  localparam int unsigned DIV_STEPS = QUO_W;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_BLOCK_WIDTH   = 3'd2,
    REG_BLOCK_HEIGHT  = 3'd3,
    REG_SQUARE_SIZE   = 3'd4
  } cfg_reg_t;

  // One divider stage: partial remainders and quotients for both axes,
  // plus the packed pixel riding along.
  typedef struct packed {
    logic [NUM_W-1:0]    rem_x;
    logic [NUM_W-1:0]    rem_y;
    logic [QUO_W-1:0]    quo_x;
    logic [QUO_W-1:0]    quo_y;
    logic [PIX565_W-1:0] pixel;
  } div_stage_t;

endpackage

`default_nettype wire

@@ src/mpd_pixel_in_if.sv @@
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying one decoded pixel and its block position.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpd_pixel_in_if;
  logic                             valid;
  logic                             ready;
  logic [mpd_pkg::BLOCK_IDX_W-1:0]  block_col;
  logic [mpd_pkg::BLOCK_IDX_W-1:0]  block_row;
  logic [mpd_pkg::PIX_IDX_W-1:0]    pixel_col;
  logic [mpd_pkg::PIX_IDX_W-1:0]    pixel_row;
  logic [mpd_pkg::COLOR_W-1:0]      red;
  logic [mpd_pkg::COLOR_W-1:0]      green;
  logic [mpd_pkg::COLOR_W-1:0]      blue;

  modport source (
    output valid, block_col, block_row, pixel_col, pixel_row, red, green, blue,
    input  ready
  );

  modport sink (
    input  valid, block_col, block_row, pixel_col, pixel_row, red, green, blue,
    output ready
  );
endinterface

`default_nettype wire

@@ src/mpd_pixel_out_if.sv @@
// ----------------------------------------------------------------------------
// Pixel output channel
// Valid/ready channel carrying a buffer write address and an RGB565 word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpd_pixel_out_if;
  logic                          valid;
  logic                          ready;
  logic [mpd_pkg::ADDR_W-1:0]    write_address;
  logic [mpd_pkg::PIX565_W-1:0]  pixel_565;

  modport source (
    output valid, write_address, pixel_565,
    input  ready
  );

  modport sink (
    input  valid, write_address, pixel_565,
    output ready
  );
endinterface

`default_nettype wire

@@ src/mcu_pixel_downscale_rgb565_top.sv @@
// Pipeline: an input transfer passes the input stage, the dividend stage,
// 8 divider steps and the output stage before its result is offered.
// Throughput: one pixel per cycle; output back-pressure stalls every full stage.
// Dropped pixels lose their valid bit and produce no output transfer.
// Reset: synchronous, active high; clears all valid bits and loads the
// configuration registers with their defaults (240, 240, 8, 8, 240).
// ----------------------------------------------------------------------------
// Pixel downscaler top level
// Nearest-neighbor scaling of decoded block pixels to a square RGB565 buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module mcu_pixel_downscale_rgb565_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [mpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mpd_pkg::CFG_W-1:0]     cfg_data,
  mpd_pixel_in_if.sink                       pix_in,
  mpd_pixel_out_if.source                    pix_out
);

  localparam int unsigned NUM_W = mpd_pkg::NUM_W;
  localparam int unsigned QUO_W = mpd_pkg::QUO_W;
  localparam int unsigned STEPS = mpd_pkg::DIV_STEPS;

  // Configuration registers.
  logic [mpd_pkg::DIM_W-1:0]   source_width;
  logic [mpd_pkg::DIM_W-1:0]   source_height;
  logic [mpd_pkg::BLK_W-1:0]   block_width;
  logic [mpd_pkg::BLK_W-1:0]   block_height;
  logic [mpd_pkg::OSIZE_W-1:0] square_size;

  // Stage 1: source coordinates and packed pixel.
  logic                        s1_valid;
  logic [mpd_pkg::SRC_W-1:0]   s1_src_x;
  logic [mpd_pkg::SRC_W-1:0]   s1_src_y;
  logic [mpd_pkg::PIX565_W-1:0] s1_pixel;

  // Divider chain: entry 0 holds the dividends, entry k the state after k steps.
  logic                        div_valid [STEPS+1];
  mpd_pkg::div_stage_t         div_stage [STEPS+1];
  logic                        div_adv   [STEPS+1];

  // Output register.
  logic                        out_valid;
  logic [mpd_pkg::ADDR_W-1:0]  out_addr;
  logic [mpd_pkg::PIX565_W-1:0] out_pixel;

  logic out_adv;
  logic s1_adv;

  // Stage 1 combinational terms.
  logic                        blk_keep;
  logic [mpd_pkg::SRC_W-1:0]   src_x_next;
  logic [mpd_pkg::SRC_W-1:0]   src_y_next;
  logic [mpd_pkg::PIX565_W-1:0] pixel_next;

  // Stage 2 combinational terms.
  logic                        range_keep;
  logic [NUM_W-1:0]            num_x_next;
  logic [NUM_W-1:0]            num_y_next;

  // Final stage combinational terms.
  logic                        buf_keep;
  logic [mpd_pkg::ADDR_W-1:0]  addr_full;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= 16'd240;
      source_height <= 16'd240;
      block_width   <= 5'd8;
      block_height  <= 5'd8;
      square_size   <= 8'd240;
    end else if (cfg_write) begin
      case (cfg_index)
        mpd_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        mpd_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data;
        mpd_pkg::REG_BLOCK_WIDTH:   block_width   <= cfg_data[mpd_pkg::BLK_W-1:0];
        mpd_pkg::REG_BLOCK_HEIGHT:  block_height  <= cfg_data[mpd_pkg::BLK_W-1:0];
        mpd_pkg::REG_SQUARE_SIZE:   square_size   <= cfg_data[mpd_pkg::OSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-stage advance: a stage loads when it is empty or its successor loads.
  always_comb begin
    out_adv = !out_valid || pix_out.ready;
    div_adv[STEPS] = !div_valid[STEPS] || out_adv;
    for (int k = STEPS - 1; k >= 0; k--) begin
      div_adv[k] = !div_valid[k] || div_adv[k+1];
    end
    s1_adv = !s1_valid || div_adv[0];
  end

  assign pix_in.ready = s1_adv;

  // Stage 1 logic: block bounds check, source coordinates, RGB565 packing.
  always_comb begin
    blk_keep = ({1'b0, pix_in.pixel_col} < block_width) &&
               ({1'b0, pix_in.pixel_row} < block_height);
    src_x_next = mpd_pkg::SRC_W'(pix_in.block_col) * mpd_pkg::SRC_W'(block_width) +
                 mpd_pkg::SRC_W'(pix_in.pixel_col);
    src_y_next = mpd_pkg::SRC_W'(pix_in.block_row) * mpd_pkg::SRC_W'(block_height) +
                 mpd_pkg::SRC_W'(pix_in.pixel_row);
    pixel_next = {pix_in.red[7:3], pix_in.green[7:2], pix_in.blue[7:3]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= pix_in.valid && blk_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_src_x <= src_x_next;
      s1_src_y <= src_y_next;
      s1_pixel <= pixel_next;
    end
  end

  // Stage 2 logic: a coordinate below its source dimension always scales
  // below the square side, so this compare settles the output-square drop.
  always_comb begin
    range_keep = (s1_src_x < mpd_pkg::SRC_W'(source_width)) &&
                 (s1_src_y < mpd_pkg::SRC_W'(source_height)) &&
                 (square_size != '0);
    num_x_next = NUM_W'(s1_src_x[mpd_pkg::DIM_W-1:0]) * NUM_W'(square_size);
    num_y_next = NUM_W'(s1_src_y[mpd_pkg::DIM_W-1:0]) * NUM_W'(square_size);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid[0] <= 1'b0;
    end else if (div_adv[0]) begin
      div_valid[0] <= s1_valid && range_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (div_adv[0]) begin
      div_stage[0].rem_x <= num_x_next;
      div_stage[0].rem_y <= num_y_next;
      div_stage[0].quo_x <= '0;
      div_stage[0].quo_y <= '0;
      div_stage[0].pixel <= s1_pixel;
    end
  end

  // Restoring divider: one quotient bit per stage, most significant first.
  for (genvar j = 0; j < STEPS; j++) begin : g_div
    localparam int unsigned SHIFT = STEPS - 1 - j;

    logic [NUM_W-1:0] dvs_x;
    logic [NUM_W-1:0] dvs_y;
    logic             bit_x;
    logic             bit_y;

    always_comb begin
      dvs_x = NUM_W'(source_width) << SHIFT;
      dvs_y = NUM_W'(source_height) << SHIFT;
      bit_x = div_stage[j].rem_x >= dvs_x;
      bit_y = div_stage[j].rem_y >= dvs_y;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_valid[j+1] <= 1'b0;
      end else if (div_adv[j+1]) begin
        div_valid[j+1] <= div_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (div_adv[j+1]) begin
        div_stage[j+1].rem_x <= bit_x ? div_stage[j].rem_x - dvs_x : div_stage[j].rem_x;
        div_stage[j+1].rem_y <= bit_y ? div_stage[j].rem_y - dvs_y : div_stage[j].rem_y;
        div_stage[j+1].quo_x <= {div_stage[j].quo_x[QUO_W-2:0], bit_x};
        div_stage[j+1].quo_y <= {div_stage[j].quo_y[QUO_W-2:0], bit_y};
        div_stage[j+1].pixel <= div_stage[j].pixel;
      end
    end
  end

  // Final stage: buffer bounds and write address, kept to its low 16 bits.
  always_comb begin
    buf_keep = (32'(div_stage[STEPS].quo_x) < 32'(mpd_pkg::BUFFER_WIDTH)) &&
               (32'(div_stage[STEPS].quo_y) < 32'(mpd_pkg::BUFFER_HEIGHT));
    addr_full = mpd_pkg::ADDR_W'(div_stage[STEPS].quo_y) *
                mpd_pkg::ADDR_W'(mpd_pkg::BUFFER_WIDTH) +
                mpd_pkg::ADDR_W'(div_stage[STEPS].quo_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= div_valid[STEPS] && buf_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_addr  <= addr_full;
      out_pixel <= div_stage[STEPS].pixel;
    end
  end

  assign pix_out.valid         = out_valid;
  assign pix_out.write_address = out_addr;
  assign pix_out.pixel_565     = out_pixel;

endmodule

`default_nettype wire

@@ verif/mcu_pixel_downscale_rgb565_top_tb.sv @@
// ----------------------------------------------------------------------------
// Pixel downscaler testbench
// Drives decoded block pixels into the downscaler under several register
// settings and idle patterns. Each output transfer is checked against a
// built-in nearest-neighbor predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module mcu_pixel_downscale_rgb565_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_PER_PHASE = 200;
  localparam int unsigned DRAIN_CYCLES     = 24;
  localparam int unsigned HOLD_CYCLES      = 300;
  localparam int unsigned CYCLE_LIMIT      = 200000;

  typedef struct packed {
    logic [mpd_pkg::BLOCK_IDX_W-1:0] block_col;
    logic [mpd_pkg::BLOCK_IDX_W-1:0] block_row;
    logic [mpd_pkg::PIX_IDX_W-1:0]   pixel_col;
    logic [mpd_pkg::PIX_IDX_W-1:0]   pixel_row;
    logic [mpd_pkg::COLOR_W-1:0]     red;
    logic [mpd_pkg::COLOR_W-1:0]     green;
    logic [mpd_pkg::COLOR_W-1:0]     blue;
  } block_pixel_t;

  localparam int unsigned BLOCK_PIXEL_W = $bits(block_pixel_t);

  typedef struct packed {
    logic [mpd_pkg::ADDR_W-1:0]   write_address;
    logic [mpd_pkg::PIX565_W-1:0] pixel_565;
  } buffer_write_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [mpd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mpd_pkg::CFG_W-1:0]     cfg_data;

  mpd_pixel_in_if  pix_in_bus ();
  mpd_pixel_out_if pix_out_bus ();

  mcu_pixel_downscale_rgb565_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in_bus),
    .pix_out   (pix_out_bus)
  );

  // Local copy of the register file, updated as each write is issued.
  logic [mpd_pkg::DIM_W-1:0]   src_w_cfg;
  logic [mpd_pkg::DIM_W-1:0]   src_h_cfg;
  logic [mpd_pkg::BLK_W-1:0]   blk_w_cfg;
  logic [mpd_pkg::BLK_W-1:0]   blk_h_cfg;
  logic [mpd_pkg::OSIZE_W-1:0] out_size_cfg;

  block_pixel_t  pixel_backlog[$];
  buffer_write_t expected_writes[$];

  bit          in_fire;
  int unsigned send_idle_pct;
  int unsigned sink_stall_pct;
  bit          hold_trigger;
  bit          hold_done;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned accepted_count;
  int unsigned dropped_count;
  int unsigned checked_count;
  int unsigned setting_count;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Nearest-neighbor mapping of one block pixel; returns 0 when it is dropped.
  function automatic bit downscale_pixel(input block_pixel_t px, output buffer_write_t wr);
    longint unsigned sx;
    longint unsigned sy;
    longint unsigned dx;
    longint unsigned dy;
    wr = '0;
    if (px.pixel_col >= blk_w_cfg || px.pixel_row >= blk_h_cfg) return 1'b0;
    if (src_w_cfg == 0 || src_h_cfg == 0 || out_size_cfg == 0) return 1'b0;
    sx = px.block_col;
    sx = sx * blk_w_cfg + px.pixel_col;
    sy = px.block_row;
    sy = sy * blk_h_cfg + px.pixel_row;
    dx = (sx * out_size_cfg) / src_w_cfg;
    dy = (sy * out_size_cfg) / src_h_cfg;
    if (dx >= out_size_cfg || dx >= mpd_pkg::BUFFER_WIDTH) return 1'b0;
    if (dy >= out_size_cfg || dy >= mpd_pkg::BUFFER_HEIGHT) return 1'b0;
    wr.write_address = mpd_pkg::ADDR_W'(dy * mpd_pkg::BUFFER_WIDTH + dx);
    wr.pixel_565     = {px.red[7:3], px.green[7:2], px.blue[7:3]};
    return 1'b1;
  endfunction

  // Picks a block and in-block index for one axis, mostly inside the image.
  function automatic void place_coord(input int unsigned dim, input int unsigned blk,
                                      input bit at_edge,
                                      output logic [mpd_pkg::BLOCK_IDX_W-1:0] bidx,
                                      output logic [mpd_pkg::PIX_IDX_W-1:0] pidx);
    int unsigned s;
    if (at_edge) begin
      case ($urandom_range(2))
        0:       s = 0;
        1:       s = dim - 1;
        default: s = dim;
      endcase
    end else begin
      s = $urandom_range(dim - 1, 0);
    end
    bidx = mpd_pkg::BLOCK_IDX_W'(s / blk);
    pidx = mpd_pkg::PIX_IDX_W'(s % blk);
  endfunction

  task automatic queue_pixel(input int unsigned bc, input int unsigned br, input int unsigned pc,
                             input int unsigned pr, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
    block_pixel_t px;
    px.block_col = mpd_pkg::BLOCK_IDX_W'(bc);
    px.block_row = mpd_pkg::BLOCK_IDX_W'(br);
    px.pixel_col = mpd_pkg::PIX_IDX_W'(pc);
    px.pixel_row = mpd_pkg::PIX_IDX_W'(pr);
    px.red       = r;
    px.green     = g;
    px.blue      = b;
    pixel_backlog.push_back(px);
  endtask

  // Mostly in-image pixels with random color, some at the image border,
  // the rest fully random fields.
  task automatic queue_random(input int unsigned count);
    block_pixel_t px;
    int unsigned  roll;
    repeat (count) begin
      roll = $urandom_range(99);
      px   = block_pixel_t'(BLOCK_PIXEL_W'({$urandom, $urandom}));
      if (roll < 85) begin
        place_coord(src_w_cfg, blk_w_cfg, roll >= 75 && $urandom_range(1) == 1,
                    px.block_col, px.pixel_col);
        place_coord(src_h_cfg, blk_h_cfg, roll >= 75 && $urandom_range(1) == 1,
                    px.block_row, px.pixel_row);
      end
      pixel_backlog.push_back(px);
    end
  endtask

  task automatic write_register(input mpd_pkg::cfg_reg_t idx,
                                input logic [mpd_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    case (idx)
      mpd_pkg::REG_SOURCE_WIDTH:  src_w_cfg    = value[mpd_pkg::DIM_W-1:0];
      mpd_pkg::REG_SOURCE_HEIGHT: src_h_cfg    = value[mpd_pkg::DIM_W-1:0];
      mpd_pkg::REG_BLOCK_WIDTH:   blk_w_cfg    = value[mpd_pkg::BLK_W-1:0];
      mpd_pkg::REG_BLOCK_HEIGHT:  blk_h_cfg    = value[mpd_pkg::BLK_W-1:0];
      mpd_pkg::REG_SQUARE_SIZE:   out_size_cfg = value[mpd_pkg::OSIZE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic apply_setting(input int unsigned sw, input int unsigned sh,
                               input int unsigned bw, input int unsigned bh,
                               input int unsigned osize);
    write_register(mpd_pkg::REG_SOURCE_WIDTH,  mpd_pkg::CFG_W'(sw));
    write_register(mpd_pkg::REG_SOURCE_HEIGHT, mpd_pkg::CFG_W'(sh));
    write_register(mpd_pkg::REG_BLOCK_WIDTH,   mpd_pkg::CFG_W'(bw));
    write_register(mpd_pkg::REG_BLOCK_HEIGHT,  mpd_pkg::CFG_W'(bh));
    write_register(mpd_pkg::REG_SQUARE_SIZE,   mpd_pkg::CFG_W'(osize));
    setting_count++;
  endtask

  // Aligns to a rising edge and selects the idle pattern for the phase.
  task automatic begin_phase(input idle_mode_t mode);
    @(posedge clk);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 64; sink_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  sink_stall_pct = 64; end
      IDLE_BOTH:     begin send_idle_pct = 10; sink_stall_pct = 10; end
      default:       begin send_idle_pct = 0;  sink_stall_pct = 0;  end
    endcase
  endtask

  // Waits until every pixel is sent and every result seen, then lets
  // dropped pixels still in the pipeline run out.
  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_backlog.size() != 0 || pix_in_bus.valid || expected_writes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Input driver: holds an offered pixel until its transfer, then offers the
  // next one or idles.
  always @(negedge clk) begin : drive_pixels
    block_pixel_t px;
    if (!pix_in_bus.valid || in_fire) begin
      if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        px = pixel_backlog.pop_front();
        pix_in_bus.block_col <= px.block_col;
        pix_in_bus.block_row <= px.block_row;
        pix_in_bus.pixel_col <= px.pixel_col;
        pix_in_bus.pixel_row <= px.pixel_row;
        pix_in_bus.red       <= px.red;
        pix_in_bus.green     <= px.green;
        pix_in_bus.blue      <= px.blue;
        pix_in_bus.valid     <= 1'b1;
      end else begin
        pix_in_bus.valid <= 1'b0;
      end
    end
  end

  // Output ready: random stalls, plus one long hold-off counted here.
  always @(negedge clk) begin : drive_ready
    if (hold_trigger && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      pix_out_bus.ready <= 1'b0;
    end else begin
      pix_out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Monitor: predicts on each input transfer, checks each output transfer.
  always @(posedge clk) begin : watch_transfers
    block_pixel_t  px;
    buffer_write_t wr;
    buffer_write_t want;
    in_fire = !rst && pix_in_bus.valid === 1'b1 && pix_in_bus.ready === 1'b1;
    if (in_fire) begin
      px.block_col = pix_in_bus.block_col;
      px.block_row = pix_in_bus.block_row;
      px.pixel_col = pix_in_bus.pixel_col;
      px.pixel_row = pix_in_bus.pixel_row;
      px.red       = pix_in_bus.red;
      px.green     = pix_in_bus.green;
      px.blue      = pix_in_bus.blue;
      accepted_count++;
      if (downscale_pixel(px, wr)) expected_writes.push_back(wr);
      else dropped_count++;
    end
    if (!rst && pix_out_bus.valid === 1'b1 && pix_out_bus.ready === 1'b1) begin
      if (expected_writes.size() == 0) begin
        error_count++;
        $display("%0t: unexpected write: expected none, actual address %h pixel %h",
                 $realtime, pix_out_bus.write_address, pix_out_bus.pixel_565);
      end else begin
        want = expected_writes.pop_front();
        checked_count++;
        if (pix_out_bus.write_address !== want.write_address) begin
          error_count++;
          $display("%0t: write_address mismatch: expected %h, actual %h",
                   $realtime, want.write_address, pix_out_bus.write_address);
        end
        if (pix_out_bus.pixel_565 !== want.pixel_565) begin
          error_count++;
          $display("%0t: pixel_565 mismatch: expected %h, actual %h",
                   $realtime, want.pixel_565, pix_out_bus.pixel_565);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run limit of %0d cycles reached with %0d results outstanding.",
               CYCLE_LIMIT, expected_writes.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    rst                  = 1'b1;
    cfg_write            = 1'b0;
    cfg_index            = mpd_pkg::REG_SOURCE_WIDTH;
    cfg_data             = '0;
    pix_in_bus.valid     = 1'b0;
    pix_in_bus.block_col = '0;
    pix_in_bus.block_row = '0;
    pix_in_bus.pixel_col = '0;
    pix_in_bus.pixel_row = '0;
    pix_in_bus.red       = '0;
    pix_in_bus.green     = '0;
    pix_in_bus.blue      = '0;
    pix_out_bus.ready    = 1'b0;
    send_idle_pct        = 0;
    sink_stall_pct       = 0;
    src_w_cfg            = 16'd240;
    src_h_cfg            = 16'd240;
    blk_w_cfg            = 5'd8;
    blk_h_cfg            = 5'd8;
    out_size_cfg         = 8'd240;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: corners, block overrun, image border and color extremes.
    begin_phase(IDLE_NONE);
    queue_pixel(0, 0, 0, 0, 8'h00, 8'h00, 8'h00);
    queue_pixel(0, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF);
    queue_pixel(29, 29, 7, 7, 8'hA5, 8'h5A, 8'hC3);
    queue_pixel(30, 0, 0, 0, 8'h12, 8'h34, 8'h56);
    queue_pixel(0, 30, 0, 0, 8'h07, 8'h03, 8'h07);
    queue_pixel(3, 4, 8, 0, 8'hF8, 8'hFC, 8'hF8);
    queue_pixel(3, 4, 0, 15, 8'h80, 8'h40, 8'h20);
    queue_pixel(8191, 8191, 15, 15, 8'hFF, 8'h00, 8'hFF);
    queue_pixel(8191, 0, 0, 0, 8'h00, 8'hFF, 8'h00);
    queue_pixel(15, 17, 3, 5, 8'h5A, 8'hA5, 8'h3C);
    queue_random(RANDOM_PER_PHASE);
    wait_drained();

    // Largest image with 16x16 blocks; last column and row.
    apply_setting(65535, 65535, 16, 16, 240);
    begin_phase(IDLE_SENDER);
    queue_pixel(4095, 4095, 14, 14, 8'hFF, 8'hFF, 8'hFF);
    queue_pixel(4095, 4095, 15, 15, 8'h11, 8'h22, 8'h33);
    queue_pixel(4095, 0, 15, 0, 8'hC0, 8'h30, 8'h0C);
    queue_random(RANDOM_PER_PHASE);
    wait_drained();

    // Smallest image and a one-pixel output square.
    apply_setting(1, 1, 8, 8, 1);
    begin_phase(IDLE_RECEIVER);
    queue_pixel(0, 0, 0, 0, 8'h9C, 8'h63, 8'hE7);
    queue_pixel(0, 0, 1, 0, 8'h9C, 8'h63, 8'hE7);
    queue_pixel(0, 0, 0, 1, 8'h9C, 8'h63, 8'hE7);
    queue_random(RANDOM_PER_PHASE);
    wait_drained();

    apply_setting(640, 480, 16, 8, 120);
    begin_phase(IDLE_BOTH);
    queue_random(RANDOM_PER_PHASE);
    wait_drained();

    // Upscaling with 12x9 blocks; output held off to back the pipe up.
    apply_setting(100, 37, 12, 9, 240);
    begin_phase(IDLE_NONE);
    hold_trigger = 1'b1;
    queue_random(RANDOM_PER_PHASE);
    wait_drained();

    apply_setting(320, 240, 9, 16, 200);
    begin_phase(IDLE_RECEIVER);
    queue_random(RANDOM_PER_PHASE);
    wait_drained();

    apply_setting(4000, 3000, 8, 15, 64);
    begin_phase(IDLE_BOTH);
    queue_random(RANDOM_PER_PHASE);
    wait_drained();

    $display("Sent %0d pixel transfers over %0d register settings plus reset values.",
             accepted_count, setting_count);
    $display("Checked %0d buffer writes, %0d pixels dropped, %0d errors.",
             checked_count, dropped_count, error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
